// ----- hw/rtl/sseg_pkg.sv -----
// shared types, constants and helpers for the seven-segment frame encoder
`timescale 1ns / 1ps

package sseg_pkg;

	localparam int DigitCount = 9;
	localparam int PosWidth   = 4;

	localparam logic [12:0] TimerMax = 13'd5999;
	localparam logic [6:0]  ScoreMax = 7'd99;
	localparam logic [3:0]  PeriodMax = 4'd9;
	localparam logic [3:0]  DarkNumeral = 4'd10;

	localparam logic [PosWidth-1:0] LastPos = PosWidth'(DigitCount - 1);
	localparam int TimerDigits = 4;

	// reciprocal of sixty, exact for every timer value up to the saturation point
	localparam logic [14:0] Recip60 = 15'd17477;
	localparam int Recip60Shift = 20;
	// reciprocal of ten, exact for values below one hundred
	localparam logic [7:0] Recip10 = 8'd205;
	localparam int Recip10Shift = 11;

	localparam logic [15:0] SelBase = 16'h0080;
	localparam logic [6:0]  SegMask = 7'h7F;
	localparam logic [6:0]  SegDark = 7'h7F;

	typedef logic [3:0] numeral_t;
	typedef numeral_t frame_t [DigitCount];

	typedef struct packed {
		numeral_t tens;
		numeral_t units;
	} split_t;

	// tens and units of a value below one hundred
	function automatic split_t split10(input logic [6:0] x);
		logic [14:0] prod;
		logic [6:0]  rem;
		split_t      r;
		prod    = 15'(x) * 15'(Recip10);
		r.tens  = prod[Recip10Shift +: 4];
		rem     = x - 7'({r.tens, 3'b000}) - 7'({r.tens, 1'b0});
		r.units = rem[3:0];
		return r;
	endfunction

	// active-low segments g..a
	function automatic logic [6:0] seg_lookup(input numeral_t n);
		logic [6:0] s;
		case (n)
			4'd0: s = 7'h40;
			4'd1: s = 7'h79;
			4'd2: s = 7'h24;
			4'd3: s = 7'h30;
			4'd4: s = 7'h19;
			4'd5: s = 7'h12;
			4'd6: s = 7'h03;
			4'd7: s = 7'h78;
			4'd8: s = 7'h00;
			4'd9: s = 7'h18;
			default: s = SegDark;
		endcase
		return s;
	endfunction

	function automatic logic [15:0] make_word(input logic [PosWidth-1:0] pos, input numeral_t n);
		return (SelBase << pos) | {9'd0, seg_lookup(n) & SegMask};
	endfunction

endpackage

// ----- hw/rtl/sseg_digit_pipe.sv -----
// four-stage pipeline turning a frame request into nine numerals
`timescale 1ns / 1ps

module sseg_digit_pipe import sseg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [12:0] timer_seconds,
	input  logic [6:0]  score_left,
	input  logic [6:0]  score_right,
	input  logic [3:0]  period_number,
	input  logic        blank_timer,
	output logic        frame_valid,
	output frame_t      frame,
	input  logic        frame_ready
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	// stage 1: saturation
	logic [12:0] t_s1;
	logic [6:0]  sl_s1, sr_s1;
	numeral_t    per_s1;
	logic        blank_s1;

	// stage 2: minutes, score digits
	logic [12:0] t_s2;
	logic [6:0]  mm_s2;
	split_t      sl_s2, sr_s2;
	numeral_t    per_s2;
	logic        blank_s2;

	// stage 3: seconds, minute digits
	logic [5:0]  ss_s3;
	split_t      mm_s3, sl_s3, sr_s3;
	numeral_t    per_s3;
	logic        blank_s3;

	// stage 4: numerals
	frame_t      frame_s4;

	logic [27:0] mm_prod;
	logic [12:0] ss_full;
	split_t      ss_split;

	assign adv4 = !v_s4 || frame_ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign busy = !adv1;

	assign mm_prod  = 28'(t_s1) * 28'(Recip60);
	assign ss_full  = t_s2 - (13'(mm_s2) << 6) + (13'(mm_s2) << 2);
	assign ss_split = split10({1'b0, ss_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= start;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			t_s1     <= (timer_seconds > TimerMax) ? TimerMax : timer_seconds;
			sl_s1    <= (score_left > ScoreMax) ? ScoreMax : score_left;
			sr_s1    <= (score_right > ScoreMax) ? ScoreMax : score_right;
			per_s1   <= (period_number > PeriodMax) ? DarkNumeral : period_number;
			blank_s1 <= blank_timer;
		end
		if (adv2) begin
			t_s2     <= t_s1;
			mm_s2    <= mm_prod[Recip60Shift +: 7];
			sl_s2    <= split10(sl_s1);
			sr_s2    <= split10(sr_s1);
			per_s2   <= per_s1;
			blank_s2 <= blank_s1;
		end
		if (adv3) begin
			ss_s3    <= ss_full[5:0];
			mm_s3    <= split10(mm_s2);
			sl_s3    <= sl_s2;
			sr_s3    <= sr_s2;
			per_s3   <= per_s2;
			blank_s3 <= blank_s2;
		end
		if (adv4) begin
			frame_s4[0] <= blank_s3 ? DarkNumeral : mm_s3.tens;
			frame_s4[1] <= blank_s3 ? DarkNumeral : mm_s3.units;
			frame_s4[2] <= blank_s3 ? DarkNumeral : ss_split.tens;
			frame_s4[3] <= blank_s3 ? DarkNumeral : ss_split.units;
			frame_s4[4] <= sl_s3.tens;
			frame_s4[5] <= sl_s3.units;
			frame_s4[6] <= sr_s3.tens;
			frame_s4[7] <= sr_s3.units;
			frame_s4[8] <= per_s3;
		end
	end

	assign frame_valid = v_s4;
	assign frame       = frame_s4;

endmodule

// ----- hw/rtl/sseg_word_serializer.sv -----
// frame buffer and word emitter, one drive word per cycle while a frame is held
`timescale 1ns / 1ps

module sseg_word_serializer import sseg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	input  frame_t              frame,
	output logic                frame_ready,
	output logic                strobe,
	output logic [15:0]         drive_word,
	output logic [PosWidth-1:0] digit_position,
	output logic                last_word
);

	frame_t              buf_q;
	logic                active_q;
	logic [PosWidth-1:0] cnt_q;
	logic                strobe_q;
	logic [15:0]         word_q;
	logic [PosWidth-1:0] pos_q;
	logic                last_q;
	logic                load;
	logic                at_last;

	assign at_last     = (cnt_q == LastPos);
	assign frame_ready = !active_q || at_last;
	assign load        = frame_valid && frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				active_q <= !at_last;
				cnt_q    <= cnt_q + PosWidth'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) buf_q <= frame;
		word_q <= make_word(cnt_q, buf_q[cnt_q]);
		pos_q  <= cnt_q;
		last_q <= at_last;
	end

	assign strobe         = strobe_q;
	assign drive_word     = word_q;
	assign digit_position = pos_q;
	assign last_word      = strobe_q && last_q;

endmodule

// ----- hw/rtl/seven_segment_frame_encoder.sv -----
// top level: frame request in, nine seven-segment drive words out
// first word strobed after the pipeline stages, the frame buffer and the word register
// throughput: one word per cycle while a frame is held, set by the single result port
// busy rises only while the word emitter still holds a frame and the pipeline is full
// the receiver cannot stall; every strobed word is taken in its own cycle
// reset clears all valid bits and the emitter; no frame is in flight afterwards
`timescale 1ns / 1ps

module seven_segment_frame_encoder import sseg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [12:0] timer_seconds,
	input  logic [6:0]  score_left,
	input  logic [6:0]  score_right,
	input  logic [3:0]  period_number,
	input  logic        blank_timer,
	output logic        strobe,
	output logic [15:0] drive_word,
	output logic [3:0]  digit_position,
	output logic        last_word
);

	// handover between the numeral pipeline and the word emitter
	logic   frame_valid;
	logic   frame_ready;
	frame_t frame;

	// saturation, divide by sixty, decimal split and blanking over four stages
	sseg_digit_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.timer_seconds (timer_seconds),
		.score_left    (score_left),
		.score_right   (score_right),
		.period_number (period_number),
		.blank_timer   (blank_timer),
		.frame_valid   (frame_valid),
		.frame         (frame),
		.frame_ready   (frame_ready)
	);

	// buffers one frame and walks digit positions 0 to 8, taking the next frame
	// in the cycle its counter reaches position 8 so frames run back to back
	sseg_word_serializer u_ser (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid    (frame_valid),
		.frame          (frame),
		.frame_ready    (frame_ready),
		.strobe         (strobe),
		.drive_word     (drive_word),
		.digit_position (digit_position),
		.last_word      (last_word)
	);

endmodule
